@@ rtl/core/clip_distortion_feedback_delay_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clip distortion feedback delay
// Concurrent checks that switch to empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CLIP_DISTORTION_FEEDBACK_DELAY_MACROS_SVH
`define CLIP_DISTORTION_FEEDBACK_DELAY_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define CDFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdfd check failed");

// Next-cycle implication, disabled during reset
`define CDFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdfd check failed");

`else

`define CDFD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CDFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/cdfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cdfd_pkg
// Shared constants, register indexes and control structs of the delay block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdfd_pkg;

  // Sample and stream widths
  localparam int DATA_W       = 16;
  localparam int TDATA_W      = 32;
  localparam int CFG_IDX_W    = 2;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF    = 65536;
  localparam int CHANNELS_DEF = 2;

  // Fixed-point constants
  localparam int ONE_Q15      = 32768;
  localparam int CLIP_LIM     = 328;
  localparam int IN_GAIN      = 9830;
  localparam int MAKEUP_RECIP = 52429;   // ceil(2^18 / 5)
  localparam int RECIP_SHIFT  = 18;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd2;

  // Register reset values
  localparam logic [DATA_W-1:0] DELAY_RST    = 16'd1;
  localparam logic [DATA_W-1:0] FEEDBACK_RST = 16'd9830;
  localparam logic [DATA_W-1:0] MIX_RST      = 16'd0;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic mul1;
    logic mul2;
    logic mul3;
    logic write;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic dly_busy;
    logic out_stall;
  } dp_stat_t;

endpackage

@@ rtl/core/cdfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdfd_ctrl
// Sequencer: store clearing after reset, then the per-request step order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "clip_distortion_feedback_delay_macros.svh"

module cdfd_ctrl
  import cdfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_MUL3  = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and the next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !stat.dly_busy;
        if (in_valid && !stat.dly_busy) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        // Wait until the output register can take the result
        if (!stat.out_stall) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  `CDFD_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == S_MUL1)
  `CDFD_ASSERT_IMPL(a_no_ready_clear, clk, rst, state == S_CLEAR, !in_ready)
  `CDFD_ASSERT_NEXT(a_stall_holds, clk, rst, (state == S_WRITE) && stat.out_stall, state == S_WRITE)

endmodule

@@ rtl/core/cdfd_datapath.sv @@
// ----------------------------------------------------------------------------
// cdfd_datapath
// Config registers, distortion lanes, delay store and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "clip_distortion_feedback_delay_macros.svh"

module cdfd_datapath
  import cdfd_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic [TDATA_W-1:0]   in_data,
  output logic [TDATA_W-1:0]   out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int MW = CHANNELS * DATA_W;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[DATA_W-1:0];
  endfunction

  // Configuration registers
  logic [DATA_W-1:0] dly_r;
  logic [DATA_W-1:0] fb_r;
  logic [DATA_W-1:0] mix_r;
  logic [DATA_W-1:0] g_r;
  logic              dly_busy;

  // Makeup gain 1 - mix/2.5 through a reciprocal of five
  logic [16:0] g_num;
  logic [32:0] g_prod;
  assign g_num  = {mix_r, 1'b0} + 17'd2;
  assign g_prod = 33'(g_num) * 33'(MAKEUP_RECIP);

  assign dly_busy = 32'(dly_r) >= 32'(DEPTH);

  // Write registers; fold the delay below the store depth one step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_r <= DELAY_RST;
      fb_r  <= FEEDBACK_RST;
      mix_r <= MIX_RST;
      g_r   <= 16'(ONE_Q15);
    end else begin
      g_r <= 16'(17'(ONE_Q15) - 17'(g_prod[32:RECIP_SHIFT]));
      if (cfg_valid && (cfg_index == REG_DELAY)) begin
        dly_r <= cfg_data;
      end else if (dly_busy) begin
        dly_r <= dly_r - 16'(DEPTH);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DELAY: begin
          end
          REG_FEEDBACK: begin
            fb_r <= (cfg_data > 16'(ONE_Q15)) ? 16'(ONE_Q15) : cfg_data;
          end
          REG_MIX: begin
            mix_r <= (cfg_data > 16'(ONE_Q15)) ? 16'(ONE_Q15) : cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Pointers
  logic [AW-1:0] wp;
  logic [AW-1:0] clr_addr;
  logic [AW:0]   rp_sum;
  logic [AW-1:0] rp;

  assign rp_sum = {1'b0, wp} + (AW+1)'(DEPTH) - (AW+1)'(dly_r);
  assign rp     = (rp_sum >= (AW+1)'(DEPTH)) ? AW'(rp_sum - (AW+1)'(DEPTH)) : AW'(rp_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear_en) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.write) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  // Delay store: one write port, one registered read port
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_data;
  logic [MW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.write) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      rd_data <= mem[rp];
    end
  end

  // Per-channel arithmetic lanes
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic signed [DATA_W-1:0] x_r;
    logic signed [19:0]       x10;
    logic signed [9:0]        clip;
    logic signed [16:0]       dry_gain;
    logic signed [16:0]       mix_gain;
    logic signed [32:0]       pa;
    logic signed [26:0]       pb;
    logic signed [32:0]       mix_sum;
    logic signed [16:0]       mixed;
    logic signed [33:0]       pc;
    logic signed [DATA_W-1:0] shaped;
    logic signed [30:0]       pd;
    logic signed [32:0]       pe;
    logic signed [DATA_W-1:0] dly_out;
    logic signed [17:0]       w_sum;

    assign x10      = 20'(x_r) * 20'sd10;
    assign clip     = (x10 > 20'(CLIP_LIM))  ? 10'(CLIP_LIM) :
                      (x10 < -20'(CLIP_LIM)) ? -10'(CLIP_LIM) : x10[9:0];
    assign dry_gain = $signed(17'(ONE_Q15) - {1'b0, mix_r});
    assign mix_gain = $signed({1'b0, mix_r});
    assign mix_sum  = pa + 33'(pb) + 33'sd16384;
    assign mixed    = 17'(mix_sum >>> 15);
    assign shaped   = sat16(20'((pc + 34'sd16384) >>> 15));
    assign dly_out  = $signed(rd_data[ch*DATA_W +: DATA_W]);
    assign w_sum    = 18'((pd + 31'sd16384) >>> 15) + 18'((pe + 33'sd16384) >>> 15);
    assign wdata[ch*DATA_W +: DATA_W] = sat16(20'(w_sum));

    // Capture the sample and step through the multiply chain
    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        x_r <= $signed(in_data[ch*DATA_W +: DATA_W]);
      end
      if (cmd.mul1) begin
        pa <= 33'(dry_gain) * 33'(x_r);
        pb <= 27'(mix_gain) * 27'(clip);
      end
      if (cmd.mul2) begin
        pc <= 34'(mixed) * 34'($signed({1'b0, g_r}));
      end
      if (cmd.mul3) begin
        pd <= 31'(shaped) * 31'(IN_GAIN);
        pe <= 33'($signed({1'b0, fb_r})) * 33'(dly_out);
      end
    end
  end

  // Output register
  logic [MW-1:0] out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_q <= rd_data;
    end
  end

  assign out_data = TDATA_W'(out_q);

  assign stat.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.dly_busy   = dly_busy;
  assign stat.out_stall  = out_valid && !out_ready;

  `CDFD_ASSERT_IMPL(a_write_free, clk, rst, cmd.write, !(out_valid && !out_ready))
  `CDFD_ASSERT_IMPL(a_read_folded, clk, rst, cmd.mul1, !dly_busy)
  `CDFD_ASSERT_NEXT(a_wp_step, clk, rst, cmd.write, (wp == (($past(wp) == AW'(DEPTH - 1)) ? AW'(0) : AW'($past(wp) + 1'b1))))

endmodule

@@ rtl/core/clip_distortion_feedback_delay.sv @@
// ----------------------------------------------------------------------------
// clip_distortion_feedback_delay
// Stereo hard-clip distortion followed by a feedback comb delay.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                          Content
// s_axis    in         s_tvalid s_tready s_tdata[31:0]  left_in, right_in
// m_axis    out        m_tvalid m_tready m_tdata[31:0]  left_out, right_out
// cfg       in         cfg_valid cfg_ready              cfg_index, cfg_data
//
// A request passes through the accept cycle and four steps of the
// controller, set by the chain of three dependent multiply stages and the
// store read before the write; s_tready stays low until the write is done.
// After reset the whole store is cleared with s_tready low. A delay write
// of DEPTH or more keeps s_tready low while the delay is folded below DEPTH.
// A result waiting in the output register stalls only the write step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clip_distortion_feedback_delay
  import cdfd_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,   // left_in [15:0], right_in [31:16]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // left_out [15:0], right_out [31:16]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Registers take writes at any time
  assign cfg_ready = 1'b1;

  cdfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cdfd_datapath #(
    .DEPTH    (DEPTH),
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ verif/clip_distortion_feedback_delay_test.sv @@
// ----------------------------------------------------------------------------
// clip_distortion_feedback_delay_test
// Self-checking bench for the stereo clip distortion feedback delay. Stereo
// requests go in on the slave stream. A bit-true model of the distortion
// stage and the feedback comb store predicts every delayed pair, and each
// pair on the master stream is checked against it. The registers are
// reprogrammed between phases while the block is idle, and both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clip_distortion_feedback_delay_test;
  import cdfd_pkg::*;

  localparam int STORE_DEPTH    = DEPTH_DEF;
  localparam int CHANNEL_COUNT  = CHANNELS_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_REQUESTS = 220;

  // Index past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One stereo pair, left in the low half as on tdata
  typedef struct packed {
    logic signed [DATA_W-1:0] right;
    logic signed [DATA_W-1:0] left;
  } stereo_pair_t;

  // Clip boundary and full-scale samples for the directed part
  localparam int EDGE_L [8] = '{0, 32767, -32768, 1, 32, -33, 33, -1};
  localparam int EDGE_R [8] = '{0, -32768, 32767, -1, -32, 33, -33, 16384};

  // --------------------------------------------------------------------------
  // Echo predictor and checker
  // --------------------------------------------------------------------------
  class comb_echo_board;
    bit [31:0]      echo_mem [STORE_DEPTH];
    int unsigned    wr_ptr;
    logic [15:0]    delay_len;
    logic [15:0]    fb_gain;
    logic [15:0]    mix_amt;
    stereo_pair_t   pending_echoes [$];
    int             errors;

    function new();
      wr_ptr    = 0;
      delay_len = DELAY_RST;
      fb_gain   = FEEDBACK_RST;
      mix_amt   = MIX_RST;
      errors    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_DELAY:    delay_len = val;
        REG_FEEDBACK: fb_gain   = val;
        REG_MIX:      mix_amt   = val;
        default: ;
      endcase
    endfunction

    // Divide by 2^15, rounding half up
    function longint round_q15(longint v);
      return (v + 16384) >>> 15;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Hard clip of ten times the sample, wet/dry mix, then make-up gain
    function longint shape(longint x, longint m);
      longint c;
      longint mixed;
      longint g;
      c = x * 10;
      if (c > CLIP_LIM) c = CLIP_LIM;
      if (c < -CLIP_LIM) c = -CLIP_LIM;
      mixed = round_q15((ONE_Q15 - m) * x + m * c);
      g = ONE_Q15 - (2 * m + 2) / 5;
      return clamp16(round_q15(mixed * g));
    endfunction

    // Input share plus fed-back echo, saturated
    function longint feed(longint d, longint echo, longint fb);
      return clamp16(round_q15(IN_GAIN * d) + round_q15(fb * echo));
    endfunction

    // Read the delayed pair, then write the new store entry and advance
    function stereo_pair_t predict_echo(stereo_pair_t x);
      longint       m;
      longint       fb;
      longint       lo;
      longint       ro;
      longint       lw;
      longint       rw;
      int unsigned  rp;
      bit [31:0]    word;
      stereo_pair_t echo;
      m  = (mix_amt > ONE_Q15) ? ONE_Q15 : mix_amt;
      fb = (fb_gain > ONE_Q15) ? ONE_Q15 : fb_gain;
      rp = (wr_ptr + STORE_DEPTH - (delay_len % STORE_DEPTH)) % STORE_DEPTH;
      word = echo_mem[rp];
      lo = $signed(word[15:0]);
      ro = $signed(word[31:16]);
      lw = feed(shape($signed(x.left), m), lo, fb);
      rw = feed(shape($signed(x.right), m), ro, fb);
      if (CHANNEL_COUNT < 2) begin
        ro = 0;
        rw = 0;
      end
      echo_mem[wr_ptr] = {rw[15:0], lw[15:0]};
      wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
      echo.left  = lo[15:0];
      echo.right = ro[15:0];
      return echo;
    endfunction

    function void note_pair(stereo_pair_t x);
      pending_echoes.push_back(predict_echo(x));
    endfunction

    function void check_echo(stereo_pair_t got);
      stereo_pair_t want;
      if (pending_echoes.size() == 0) begin
        errors++;
        $display("%0t: output pair %h with none expected", $time, got);
        return;
      end
      want = pending_echoes.pop_front();
      if (got.left !== want.left) begin
        errors++;
        $display("%0t: left_out expected %0d, got %0d", $time, want.left, got.left);
      end
      if (got.right !== want.right) begin
        errors++;
        $display("%0t: right_out expected %0d, got %0d", $time, want.right, got.right);
      end
    endfunction

    function int waiting();
      return pending_echoes.size();
    endfunction

    function void flag_leftovers();
      if (pending_echoes.size() != 0) begin
        errors++;
        $display("%0t: %0d output pairs never arrived", $time, pending_echoes.size());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata   = '0;   // left_in [15:0], right_in [31:16]
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;          // left_out [15:0], right_out [31:16]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  comb_echo_board board = new();

  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int rx_hold_asks   = 0;
  int rx_hold_served = 0;
  int rx_hold_left   = 0;

  clip_distortion_feedback_delay #(
    .DEPTH    (STORE_DEPTH),
    .CHANNELS (CHANNEL_COUNT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rx_hold_asks != rx_hold_served) begin
      rx_hold_served = rx_hold_asks;
      rx_hold_left   = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Check each accepted output pair
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_echo(m_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  function automatic stereo_pair_t stereo(int l, int r);
    stereo_pair_t p;
    p.left  = l[15:0];
    p.right = r[15:0];
    return p;
  endfunction

  // Offer one request, with a random gap ahead of it
  task automatic send_pair(input stereo_pair_t x);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    board.note_pair(x);
  endtask

  // Hold the sender until every expected pair is out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] dly, input logic [15:0] fb,
                              input logic [15:0] mix);
    wait_drained();
    write_reg(REG_DELAY, dly);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_MIX, mix);
  endtask

  // --------------------------------------------------------------------------
  // Random picks
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      // near the clip threshold
      1, 2: return 16'($urandom_range(96)) - 16'd48;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'(ONE_Q15);
      2: return 16'($urandom);
      default: return 16'($urandom_range(ONE_Q15));
    endcase
  endfunction

  // Mostly short delays so that echoes come back within the run
  function automatic logic [15:0] pick_delay();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: return 16'($urandom_range(200, 49));
      default: return 16'($urandom_range(48, 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int guard;
    stereo_pair_t x;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, then max gains, saturated gains, long delay
    for (int i = 0; i < 8; i++) send_pair(stereo(EDGE_L[i], EDGE_R[i]));
    program_regs(16'd2, 16'(ONE_Q15), 16'(ONE_Q15));
    write_reg(REG_SPARE, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_pair(stereo(EDGE_L[i], EDGE_R[i]));
    program_regs(16'd0, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_pair(stereo(EDGE_L[i], EDGE_R[i]));
    program_regs(16'hFFFF, 16'd0, 16'd16384);
    for (int i = 0; i < 4; i++) send_pair(stereo(EDGE_L[i], EDGE_R[i]));

    // Random phases, cycling through the idle profiles
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      program_regs(pick_delay(), pick_gain(), pick_gain());
      if ($urandom_range(1)) write_reg(REG_SPARE, 16'($urandom));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
      endcase
      // Long receiver hold-off while requests keep coming
      if (ph == 4) rx_hold_asks = rx_hold_asks + 1;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (ph == 5 && n == PHASE_REQUESTS / 2) wait_drained();
        x.left  = pick_sample();
        x.right = pick_sample();
        send_pair(x);
      end
    end

    // Drain with a bound, then report
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    s_tvalid <= 1'b0;
    guard = 0;
    while (board.waiting() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.flag_leftovers();
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ clip_distortion_feedback_delay.f @@
+incdir+rtl/core
rtl/core/cdfd_pkg.sv
rtl/core/cdfd_ctrl.sv
rtl/core/cdfd_datapath.sv
rtl/core/clip_distortion_feedback_delay.sv
verif/clip_distortion_feedback_delay_test.sv
